FILE: hw/rtl/fucm_pkg.sv
// Shared constants and types for the fisheye undistortion coordinate map.
`timescale 1ns / 1ps
`default_nettype none
package fucm_pkg;

  localparam int MAX_OUT_DIM = 4096;
  localparam int COORD_W     = 12;
  localparam int POW_W       = 47;
  localparam int N_W         = 36;
  localparam int FMAG_W      = 53;
  localparam int ND_W        = 63;
  localparam int PIX_W       = 41;
  localparam int TERM_W      = 52;

  localparam logic [POW_W-1:0] POW_CAP = {POW_W{1'b1}};
  localparam logic [ND_W-1:0]  ND_CAP  = ND_W'(64'd1 << 62);
  localparam logic [PIX_W-1:0] PIX_CAP = PIX_W'(64'd1 << 40);
  localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(MAX_OUT_DIM - 1);

  localparam logic [19:0] RST_INPUT_FOCAL = 20'd256000;
  localparam logic [23:0] RST_INV_FOCAL   = 24'd16777;
  localparam logic [19:0] RST_CENTER      = 20'd524288;

  typedef enum logic [2:0] {
    REG_INPUT_FOCAL = 3'd0,
    REG_INV_FOCAL   = 3'd1,
    REG_CENTER_X    = 3'd2,
    REG_CENTER_Y    = 3'd3,
    REG_COEF_ONE    = 3'd4,
    REG_COEF_TWO    = 3'd5,
    REG_COEF_THREE  = 3'd6,
    REG_COEF_FOUR   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [1:0][19:0]        dmag;
    logic [1:0]              dneg;
    logic [1:0][N_W-1:0]     n;
    logic [1:0][35:0]        sqh;
    logic [1:0][35:0]        sqm;
    logic [1:0][35:0]        sql;
    logic [POW_W-1:0]        r2;
    logic [POW_W-1:0]        r4;
    logic [POW_W-1:0]        r6;
    logic [POW_W-1:0]        r8;
    logic [3:0][42:0]        tph;
    logic [3:0][43:0]        tpl;
    logic [3:0][TERM_W-1:0]  tmag;
    logic [FMAG_W-1:0]       fmag;
    logic                    fneg;
    logic [1:0][3:0][44:0]   ndp;
    logic [1:0][ND_W-1:0]    nd;
    logic [1:0][1:0][51:0]   pp;
    logic [1:0][PIX_W-1:0]   pix;
  } pipe_t;

endpackage
`default_nettype wire

FILE: hw/rtl/fucm_powmul.sv
// Two-stage saturating Q.24 multiplier for the radius powers.
`timescale 1ns / 1ps
`default_nettype none
module fucm_powmul
  import fucm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic [POW_W-1:0] a,
  input  wire logic [POW_W-1:0] b,
  output logic      [POW_W-1:0] q
);

  logic [45:0] hh;
  logic [46:0] hl;
  logic [46:0] lh;
  logic [47:0] ll;
  logic [93:0] full;
  logic [69:0] shifted;

  always_ff @(posedge clk) begin
    hh <= 46'(a[46:24]) * 46'(b[46:24]);
    hl <= 47'(a[46:24]) * 47'(b[23:0]);
    lh <= 47'(a[23:0]) * 47'(b[46:24]);
    ll <= 48'(a[23:0]) * 48'(b[23:0]);
  end

  always_comb begin
    full    = (94'(hh) << 48) + (94'(hl) << 24) + (94'(lh) << 24) + 94'(ll);
    shifted = full[93:24];
  end

  always_ff @(posedge clk) begin
    q <= (shifted > 70'(POW_CAP)) ? POW_CAP : shifted[POW_W-1:0];
  end

endmodule
`default_nettype wire

FILE: hw/rtl/fisheye_undistort_coordinate_map_core.sv
// Top level of the fisheye undistortion coordinate map pipeline.
//
//   channel   handshake         words
//   input     start / busy      out_col, out_row
//   result    done (strobe)     src_col, src_row, clipped
//   config    APB psel/penable  input_focal .. coef_four at 4*index
//
// One word enters per cycle; busy is always low. The pipeline depth is set by
// the chain of three dependent radius power multiplies (two stages each)
// followed by the polynomial and the scaling multiplies.
// Synchronous reset clears the valid bits and loads the register defaults.
// The receiver cannot stall, so the pipeline never holds.
`timescale 1ns / 1ps
`default_nettype none
module fisheye_undistort_coordinate_map_core
  import fucm_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [COORD_W-1:0]  out_col,
  input  wire logic [COORD_W-1:0]  out_row,
  output logic                     done,
  output logic signed [23:0]       src_col,
  output logic signed [23:0]       src_row,
  output logic                     clipped,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [4:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic      [31:0]         prdata,
  output logic                     pready
);

  localparam int LAST = 18;

  logic [19:0]       input_focal;
  logic [23:0]       inverse_output_focal;
  logic [1:0][19:0]  center;
  logic [3:0][19:0]  coef;

  pipe_t             st   [1:LAST];
  pipe_t             nxt  [1:LAST];
  logic [LAST:1]     vld;

  logic [POW_W-1:0]  r4_q;
  logic [POW_W-1:0]  r6_q;
  logic [POW_W-1:0]  r8_q;

  logic [1:0][23:0]  res_next;
  logic              clip_next;
  reg_idx_t          ridx;
  logic              wr;

  function automatic logic [19:0] coef_mag(input logic [19:0] k);
    return k[19] ? 20'(-k) : k;
  endfunction

  assign busy  = 1'b0;
  assign pready = 1'b1;
  assign wr    = psel && penable && pwrite;
  assign ridx  = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      input_focal          <= RST_INPUT_FOCAL;
      inverse_output_focal <= RST_INV_FOCAL;
      center               <= {RST_CENTER, RST_CENTER};
      coef                 <= '0;
    end else if (wr) begin
      unique case (ridx)
        REG_INPUT_FOCAL: input_focal          <= pwdata[19:0];
        REG_INV_FOCAL:   inverse_output_focal <= pwdata[23:0];
        REG_CENTER_X:    center[0]            <= pwdata[19:0];
        REG_CENTER_Y:    center[1]            <= pwdata[19:0];
        REG_COEF_ONE:    coef[0]              <= pwdata[19:0];
        REG_COEF_TWO:    coef[1]              <= pwdata[19:0];
        REG_COEF_THREE:  coef[2]              <= pwdata[19:0];
        REG_COEF_FOUR:   coef[3]              <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_INPUT_FOCAL: prdata = {12'd0, input_focal};
      REG_INV_FOCAL:   prdata = {8'd0, inverse_output_focal};
      REG_CENTER_X:    prdata = {12'd0, center[0]};
      REG_CENTER_Y:    prdata = {12'd0, center[1]};
      REG_COEF_ONE:    prdata = {12'd0, coef[0]};
      REG_COEF_TWO:    prdata = {12'd0, coef[1]};
      REG_COEF_THREE:  prdata = {12'd0, coef[2]};
      REG_COEF_FOUR:   prdata = {12'd0, coef[3]};
      default:         prdata = '0;
    endcase
  end

  // radius powers: r4 aligned with stage 6, r6 with 8, r8 with 10
  fucm_powmul u_pow4 (.clk(clk), .a(st[4].r2), .b(st[4].r2), .q(r4_q));
  fucm_powmul u_pow6 (.clk(clk), .a(r4_q),     .b(st[6].r2), .q(r6_q));
  fucm_powmul u_pow8 (.clk(clk), .a(r6_q),     .b(st[8].r2), .q(r8_q));

  always_comb begin
    logic [1:0][COORD_W-1:0] crd;
    logic signed [21:0]      dv;
    logic [71:0]             sqf;
    logic [47:0]             sqx;
    logic [47:0]             sqy;
    logic [48:0]             r2s;
    logic [3:0][POW_W-1:0]   pw;
    logic [67:0]             tfull;
    logic signed [54:0]      facc;
    logic [88:0]             ndf;
    logic [64:0]             nds;
    logic [82:0]             pf;
    logic [58:0]             ps;

    for (int k = 2; k <= LAST; k++) begin
      nxt[k] = st[k-1];
    end

    // stage 1: clamp and center
    nxt[1] = st[1];
    crd[0] = (out_col > COORD_MAX) ? COORD_MAX : out_col;
    crd[1] = (out_row > COORD_MAX) ? COORD_MAX : out_row;
    for (int a = 0; a < 2; a++) begin
      dv = $signed({2'b00, crd[a], 8'h00}) - $signed({2'b00, center[a]});
      nxt[1].dneg[a] = dv[21];
      nxt[1].dmag[a] = dv[21] ? 20'(-dv) : 20'(dv);
    end

    // stage 2: normalize
    for (int a = 0; a < 2; a++) begin
      nxt[2].n[a] = N_W'((44'(st[1].dmag[a]) * 44'(inverse_output_focal)) >> 8);
    end

    // stage 3: square partials
    for (int a = 0; a < 2; a++) begin
      nxt[3].sqh[a] = 36'(st[2].n[a][35:18]) * 36'(st[2].n[a][35:18]);
      nxt[3].sqm[a] = 36'(st[2].n[a][35:18]) * 36'(st[2].n[a][17:0]);
      nxt[3].sql[a] = 36'(st[2].n[a][17:0]) * 36'(st[2].n[a][17:0]);
    end

    // stage 4: r squared
    sqf = (72'(st[3].sqh[0]) << 36) + (72'(st[3].sqm[0]) << 19) + 72'(st[3].sql[0]);
    sqx = sqf[71:24];
    sqf = (72'(st[3].sqh[1]) << 36) + (72'(st[3].sqm[1]) << 19) + 72'(st[3].sql[1]);
    sqy = sqf[71:24];
    r2s = 49'(sqx) + 49'(sqy);
    nxt[4].r2 = (r2s > 49'(POW_CAP)) ? POW_CAP : r2s[POW_W-1:0];

    nxt[7].r4  = r4_q;
    nxt[9].r6  = r6_q;
    nxt[11].r8 = r8_q;

    // stage 12: term partials
    pw = {st[11].r8, st[11].r6, st[11].r4, st[11].r2};
    for (int i = 0; i < 4; i++) begin
      nxt[12].tph[i] = 43'(coef_mag(coef[i])) * 43'(pw[i][46:24]);
      nxt[12].tpl[i] = 44'(coef_mag(coef[i])) * 44'(pw[i][23:0]);
    end

    // stage 13: term magnitudes
    for (int i = 0; i < 4; i++) begin
      tfull = (68'(st[12].tph[i]) << 24) + 68'(st[12].tpl[i]);
      nxt[13].tmag[i] = tfull[67:16];
    end

    // stage 14: polynomial factor
    facc = 55'sd16777216;
    for (int i = 0; i < 4; i++) begin
      if (coef[i][19]) begin
        facc = facc - $signed({3'b000, st[13].tmag[i]});
      end else begin
        facc = facc + $signed({3'b000, st[13].tmag[i]});
      end
    end
    nxt[14].fneg = facc[54];
    nxt[14].fmag = facc[54] ? FMAG_W'(-facc) : FMAG_W'(facc);

    // stage 15: distorted radius partials
    for (int a = 0; a < 2; a++) begin
      nxt[15].ndp[a][0] = 45'(st[14].n[a][35:18]) * 45'(st[14].fmag[52:27]);
      nxt[15].ndp[a][1] = 45'(st[14].n[a][35:18]) * 45'(st[14].fmag[26:0]);
      nxt[15].ndp[a][2] = 45'(st[14].n[a][17:0]) * 45'(st[14].fmag[52:27]);
      nxt[15].ndp[a][3] = 45'(st[14].n[a][17:0]) * 45'(st[14].fmag[26:0]);
    end

    // stage 16: distorted radius
    for (int a = 0; a < 2; a++) begin
      ndf = (89'(st[15].ndp[a][0]) << 45) + (89'(st[15].ndp[a][1]) << 18)
          + (89'(st[15].ndp[a][2]) << 27) + 89'(st[15].ndp[a][3]);
      nds = ndf[88:24];
      nxt[16].nd[a] = (nds > 65'(ND_CAP)) ? ND_CAP : nds[ND_W-1:0];
    end

    // stage 17: pixel scale partials
    for (int a = 0; a < 2; a++) begin
      nxt[17].pp[a][0] = 52'(st[16].nd[a][62:32]) * 52'(input_focal);
      nxt[17].pp[a][1] = 52'(st[16].nd[a][31:0]) * 52'(input_focal);
    end

    // stage 18: pixel offset
    for (int a = 0; a < 2; a++) begin
      pf = (83'(st[17].pp[a][0]) << 32) + 83'(st[17].pp[a][1]);
      ps = pf[82:24];
      nxt[18].pix[a] = (ps > 59'(PIX_CAP)) ? PIX_CAP : ps[PIX_W-1:0];
    end
  end

  always_comb begin
    logic signed [42:0] v;
    logic signed [42:0] off;
    clip_next = 1'b0;
    for (int a = 0; a < 2; a++) begin
      off = $signed({2'b00, st[LAST].pix[a]});
      if (st[LAST].dneg[a] != st[LAST].fneg) begin
        off = -off;
      end
      v = $signed({23'd0, center[a]}) + off;
      if (v > 43'sd8388607) begin
        res_next[a] = 24'h7FFFFF;
        clip_next   = 1'b1;
      end else if (v < -43'sd8388608) begin
        res_next[a] = 24'h800000;
        clip_next   = 1'b1;
      end else begin
        res_next[a] = v[23:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    st <= nxt;
    src_col <= res_next[0];
    src_row <= res_next[1];
    clipped <= clip_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[LAST-1:1], start};
      done <= vld[LAST];
    end
  end

endmodule
`default_nettype wire

FILE: verif/fucm_checker.sv
// Checker for the fisheye coordinate map: predicts each result word and compares.
`timescale 1ns / 1ps
module fucm_checker
  import fucm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [COORD_W-1:0] out_col,
  input  logic [COORD_W-1:0] out_row,
  input  logic               done,
  input  logic signed [23:0] src_col,
  input  logic signed [23:0] src_row,
  input  logic               clipped,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 fail_count,
  output int                 pending
);

  typedef struct {
    logic [23:0] col;
    logic [23:0] row;
    logic        clip;
  } coord_t;

  logic [19:0] focal_in;
  logic [23:0] inv_focal;
  logic [19:0] cx, cy;
  logic [19:0] coef [4];
  coord_t      coord_q[$];

  function automatic logic [63:0] mul_shr(logic [63:0] a, logic [63:0] b, int sh,
                                          logic [63:0] cap);
    logic [127:0] p;
    logic [127:0] r;
    p = a * b;
    r = p >> sh;
    if (r > {64'd0, cap}) return cap;
    return r[63:0];
  endfunction

  function automatic logic [23:0] axis_pos(logic [63:0] nmag, logic nneg,
                                           logic [63:0] fmag, logic fneg,
                                           logic [19:0] ctr, inout logic clip);
    logic [63:0]  nd, p;
    longint       v;
    nd = mul_shr(nmag, fmag, 24, 64'd1 << 62);
    p  = mul_shr(nd, {44'd0, focal_in}, 24, 64'd1 << 40);
    v  = longint'({44'd0, ctr}) + ((nneg != fneg) ? -longint'(p) : longint'(p));
    if (v > 64'sd8388607) begin v = 8388607; clip = 1'b1; end
    if (v < -64'sd8388608) begin v = -8388608; clip = 1'b1; end
    return v[23:0];
  endfunction

  function automatic coord_t map_coord(logic [11:0] c, logic [11:0] r);
    logic [11:0] col, row;
    longint      dx, dy, f;
    logic        xneg, yneg, fneg, clip, kneg;
    logic [63:0] nx, ny, kmag, t, fmag;
    logic [63:0] pw [4];
    coord_t      res;
    col = (c > COORD_MAX) ? COORD_MAX : c;
    row = (r > COORD_MAX) ? COORD_MAX : r;
    dx = longint'({44'd0, col, 8'd0}) - longint'({44'd0, cx});
    dy = longint'({44'd0, row, 8'd0}) - longint'({44'd0, cy});
    xneg = dx < 0;
    yneg = dy < 0;
    nx = mul_shr(xneg ? -dx : dx, {40'd0, inv_focal}, 8, '1);
    ny = mul_shr(yneg ? -dy : dy, {40'd0, inv_focal}, 8, '1);
    pw[0] = mul_shr(nx, nx, 24, '1) + mul_shr(ny, ny, 24, '1);
    if (pw[0] > {17'd0, POW_CAP}) pw[0] = {17'd0, POW_CAP};
    for (int i = 1; i < 4; i++) pw[i] = mul_shr(pw[i-1], pw[0], 24, {17'd0, POW_CAP});
    f = longint'(1) << 24;
    for (int i = 0; i < 4; i++) begin
      kneg = coef[i][19];
      kmag = kneg ? 64'h100000 - {44'd0, coef[i]} : {44'd0, coef[i]};
      t = mul_shr(kmag, pw[i], 16, '1);
      f += kneg ? -longint'(t) : longint'(t);
    end
    fneg = f < 0;
    fmag = fneg ? -f : f;
    clip = 1'b0;
    res.col = axis_pos(nx, xneg, fmag, fneg, cx, clip);
    res.row = axis_pos(ny, yneg, fmag, fneg, cy, clip);
    res.clip = clip;
    return res;
  endfunction

  assign pending = coord_q.size();

  always @(posedge clk) begin
    coord_t exp_c;
    int     errs;
    errs = 0;
    if (rst) begin
      focal_in  <= RST_INPUT_FOCAL;
      inv_focal <= RST_INV_FOCAL;
      cx        <= RST_CENTER;
      cy        <= RST_CENTER;
      for (int i = 0; i < 4; i++) coef[i] <= '0;
      coord_q.delete();
      fail_count <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[4:2]))
          REG_INPUT_FOCAL: focal_in  <= pwdata[19:0];
          REG_INV_FOCAL:   inv_focal <= pwdata[23:0];
          REG_CENTER_X:    cx        <= pwdata[19:0];
          REG_CENTER_Y:    cy        <= pwdata[19:0];
          REG_COEF_ONE:    coef[0]   <= pwdata[19:0];
          REG_COEF_TWO:    coef[1]   <= pwdata[19:0];
          REG_COEF_THREE:  coef[2]   <= pwdata[19:0];
          REG_COEF_FOUR:   coef[3]   <= pwdata[19:0];
          default: ;
        endcase
      end
      if (start && !busy) coord_q.push_back(map_coord(out_col, out_row));
      if (done) begin
        if (coord_q.size() == 0) begin
          $error("result word with nothing expected");
          errs++;
        end else begin
          exp_c = coord_q.pop_front();
          if (src_col !== exp_c.col) begin
            $error("src_col expected %0d actual %0d", $signed(exp_c.col), src_col);
            errs++;
          end
          if (src_row !== exp_c.row) begin
            $error("src_row expected %0d actual %0d", $signed(exp_c.row), src_row);
            errs++;
          end
          if (clipped !== exp_c.clip) begin
            $error("clipped expected %0b actual %0b", exp_c.clip, clipped);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end

endmodule

FILE: verif/tb_fisheye_undistort_coordinate_map_core.sv
// Testbench top: drives coordinate words and register writes, reports the verdict.
`timescale 1ns / 1ps
module tb_fisheye_undistort_coordinate_map_core;
  import fucm_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [COORD_W-1:0] out_col = '0, out_row = '0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic busy, done, clipped, pready;
  logic signed [23:0] src_col, src_row;
  logic [31:0] prdata;
  int fail_count, pending;
  int cycles = 0;
  bit calm = 1'b0;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LATENCY = 19;

  always #4 clk = ~clk;

  fisheye_undistort_coordinate_map_core u_top (.*);

  fucm_checker u_chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic reg_write(reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; paddr = {idx, 2'b00}; pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  // called at a falling edge; leaves start high so words can follow back to back
  task automatic send_coord(logic [11:0] c, logic [11:0] r);
    while (!calm && $urandom_range(99) < 15) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1; out_col = c; out_row = r;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic drain();
    start = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_coords(int cnt);
    logic [11:0] c, r;
    for (int i = 0; i < cnt; i++) begin
      calm = (i >= cnt / 3) && (i < cnt / 2);
      c = 12'($urandom); r = 12'($urandom);
      if ($urandom_range(9) == 0) c = 12'hFFF;
      if ($urandom_range(9) == 0) r = 12'h000;
      send_coord(c, r);
    end
    calm = 1'b0;
  endtask

  task automatic set_regs(logic [19:0] fi, logic [23:0] inv, logic [19:0] x, logic [19:0] y,
                          logic [19:0] k1, logic [19:0] k2, logic [19:0] k3, logic [19:0] k4);
    reg_write(REG_INPUT_FOCAL, {12'd0, fi});
    reg_write(REG_INV_FOCAL, {8'd0, inv});
    reg_write(REG_CENTER_X, {12'd0, x});
    reg_write(REG_CENTER_Y, {12'd0, y});
    reg_write(REG_COEF_ONE, {12'd0, k1});
    reg_write(REG_COEF_TWO, {12'd0, k2});
    reg_write(REG_COEF_THREE, {12'd0, k3});
    reg_write(REG_COEF_FOUR, {12'd0, k4});
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: corners, center, default setup
    send_coord(12'd0, 12'd0);
    send_coord(12'hFFF, 12'hFFF);
    send_coord(12'd2048, 12'd2048);
    send_coord(12'd0, 12'hFFF);
    send_coord(12'hFFF, 12'd0);
    drain();
    // typical distortion
    set_regs(20'd200000, 24'd20000, 20'd300000, 20'd250000,
             20'hF0000, 20'h04000, 20'hFF000, 20'h00100);
    send_coord(12'd1171, 12'd976);
    send_coord(12'd0, 12'd0);
    send_coord(12'hFFF, 12'hFFF);
    send_coord(12'd100, 12'd3000);
    drain();
    // extreme: power and product saturation, clipping
    set_regs(20'hFFFFF, 24'hFFFFFF, 20'd0, 20'hFFFFF,
             20'h7FFFF, 20'h80000, 20'h7FFFF, 20'h80000);
    send_coord(12'd0, 12'd0);
    send_coord(12'hFFF, 12'hFFF);
    send_coord(12'd1, 12'd4094);
    send_coord(12'h800, 12'h7FF);
    drain();
    // zero factors
    set_regs(20'd0, 24'd0, 20'd0, 20'd0, 20'h80000, 20'h80000, 20'h80000, 20'h80000);
    send_coord(12'hFFF, 12'd5);
    send_coord(12'd0, 12'd0);
    drain();

    set_regs(20'd256000, 24'd16777, 20'd524288, 20'd524288, 20'd0, 20'd0, 20'd0, 20'd0);
    random_coords(250);
    drain();
    set_regs(20'd300000, 24'd30000, 20'd400000, 20'd600000,
             20'hFC000, 20'h01000, 20'hFFF00, 20'h00010);
    random_coords(200);
    drain();
    for (int ph = 0; ph < 5; ph++) begin
      set_regs(20'($urandom), 24'($urandom), 20'($urandom), 20'($urandom),
               20'($urandom), 20'($urandom), 20'($urandom), 20'($urandom));
      random_coords(50);
      drain();
    end

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: fisheye_undistort_coordinate_map_core.f
hw/rtl/fucm_pkg.sv
hw/rtl/fucm_powmul.sv
hw/rtl/fisheye_undistort_coordinate_map_core.sv
verif/fucm_checker.sv
verif/tb_fisheye_undistort_coordinate_map_core.sv
